>>> hdl/ftsm_pkg.sv
`default_nettype none

package ftsm_pkg;

    localparam int BOUND_BITS = 24;
    localparam int CFG_IDX_BITS = 3;
    localparam int BUCKETS = 5;

    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_SNAP  = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOUND_FIRST  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOUND_SECOND = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOUND_THIRD  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOUND_FOURTH = 3'd4;

    localparam logic [BOUND_BITS-1:0] BOUND_FIRST_RST  = 24'd17500;
    localparam logic [BOUND_BITS-1:0] BOUND_SECOND_RST = 24'd21000;
    localparam logic [BOUND_BITS-1:0] BOUND_THIRD_RST  = 24'd26000;
    localparam logic [BOUND_BITS-1:0] BOUND_FOURTH_RST = 24'd34500;

    typedef struct packed {
        logic                  enable;
        logic [BOUND_BITS-1:0] bound_first;
        logic [BOUND_BITS-1:0] bound_second;
        logic [BOUND_BITS-1:0] bound_third;
        logic [BOUND_BITS-1:0] bound_fourth;
    } cfg_t;

endpackage

`default_nettype wire

>>> hdl/ftsm_cfg.sv
`default_nettype none

module ftsm_cfg
    import ftsm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [BOUND_BITS-1:0]   cfg_data,
    output cfg_t                         cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ENABLE:       cfg_next.enable       = cfg_data[0];
                CFG_BOUND_FIRST:  cfg_next.bound_first  = cfg_data;
                CFG_BOUND_SECOND: cfg_next.bound_second = cfg_data;
                CFG_BOUND_THIRD:  cfg_next.bound_third  = cfg_data;
                CFG_BOUND_FOURTH: cfg_next.bound_fourth = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable       <= 1'b0;
            cfg_reg.bound_first  <= BOUND_FIRST_RST;
            cfg_reg.bound_second <= BOUND_SECOND_RST;
            cfg_reg.bound_third  <= BOUND_THIRD_RST;
            cfg_reg.bound_fourth <= BOUND_FOURTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/ftsm_stats.sv
`default_nettype none

module ftsm_stats
    import ftsm_pkg::*;
#(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  go,
    input  wire logic [1:0]            cmd,
    input  wire logic [TIME_BITS-1:0]  now,
    input  wire cfg_t                  cfg,
    output logic [COUNT_BITS-1:0]      frames,
    output logic [TIME_BITS-1:0]       isum,
    output logic [TIME_BITS-1:0]       imax,
    output logic [TIME_BITS-1:0]       psum,
    output logic [COUNT_BITS-1:0]      hist [BUCKETS]
);

    logic [TIME_BITS-1:0]  last_begin_reg,  last_begin_next;
    logic                  have_begin_reg,  have_begin_next;
    logic [TIME_BITS-1:0]  pstart_reg,      pstart_next;
    logic [COUNT_BITS-1:0] frames_reg,      frames_next;
    logic [TIME_BITS-1:0]  isum_reg,        isum_next;
    logic [TIME_BITS-1:0]  imax_reg,        imax_next;
    logic [TIME_BITS-1:0]  psum_reg,        psum_next;
    logic [COUNT_BITS-1:0] hist_reg [BUCKETS];
    logic [COUNT_BITS-1:0] hist_next [BUCKETS];

    logic [TIME_BITS-1:0]  iv;
    logic [TIME_BITS-1:0]  pv;
    logic [TIME_BITS:0]    isum_wide;
    logic [TIME_BITS:0]    psum_wide;
    logic [BUCKETS-1:0]    hit;

    assign iv        = now - last_begin_reg;
    assign pv        = now - pstart_reg;
    assign isum_wide = {1'b0, isum_reg} + {1'b0, iv};
    assign psum_wide = {1'b0, psum_reg} + {1'b0, pv};

    // first bound not exceeded picks the bucket
    always_comb
    begin
        hit = '0;
        priority if (iv <= TIME_BITS'(cfg.bound_first))
            hit[0] = 1'b1;
        else if (iv <= TIME_BITS'(cfg.bound_second))
            hit[1] = 1'b1;
        else if (iv <= TIME_BITS'(cfg.bound_third))
            hit[2] = 1'b1;
        else if (iv <= TIME_BITS'(cfg.bound_fourth))
            hit[3] = 1'b1;
        else
            hit[4] = 1'b1;
    end

    always_comb
    begin
        last_begin_next = last_begin_reg;
        have_begin_next = have_begin_reg;
        pstart_next     = pstart_reg;
        frames_next     = frames_reg;
        isum_next       = isum_reg;
        imax_next       = imax_reg;
        psum_next       = psum_reg;
        for (int i = 0; i < BUCKETS; i++)
        begin
            hist_next[i] = hist_reg[i];
        end
        if (go)
        begin
            if (cmd == CMD_BEGIN && cfg.enable)
            begin
                if (have_begin_reg)
                begin
                    if (frames_reg != '1)
                        frames_next = frames_reg + COUNT_BITS'(1);
                    isum_next = isum_wide[TIME_BITS] ? '1 : isum_wide[TIME_BITS-1:0];
                    if (iv > imax_reg)
                        imax_next = iv;
                    for (int i = 0; i < BUCKETS; i++)
                    begin
                        if (hit[i] && hist_reg[i] != '1)
                            hist_next[i] = hist_reg[i] + COUNT_BITS'(1);
                    end
                end
                last_begin_next = now;
                have_begin_next = 1'b1;
                pstart_next     = now;
            end
            else if (cmd == CMD_END && cfg.enable && have_begin_reg)
            begin
                psum_next = psum_wide[TIME_BITS] ? '1 : psum_wide[TIME_BITS-1:0];
            end
            else if (cmd == CMD_SNAP)
            begin
                frames_next = '0;
                isum_next   = '0;
                imax_next   = '0;
                psum_next   = '0;
                for (int i = 0; i < BUCKETS; i++)
                begin
                    hist_next[i] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_begin_reg <= '0;
            have_begin_reg <= 1'b0;
            pstart_reg     <= '0;
            frames_reg     <= '0;
            isum_reg       <= '0;
            imax_reg       <= '0;
            psum_reg       <= '0;
            for (int i = 0; i < BUCKETS; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            last_begin_reg <= last_begin_next;
            have_begin_reg <= have_begin_next;
            pstart_reg     <= pstart_next;
            frames_reg     <= frames_next;
            isum_reg       <= isum_next;
            imax_reg       <= imax_next;
            psum_reg       <= psum_next;
            for (int i = 0; i < BUCKETS; i++)
            begin
                hist_reg[i] <= hist_next[i];
            end
        end
    end

    assign frames = frames_reg;
    assign isum   = isum_reg;
    assign imax   = imax_reg;
    assign psum   = psum_reg;
    always_comb
    begin
        for (int i = 0; i < BUCKETS; i++)
        begin
            hist[i] = hist_reg[i];
        end
    end

    a_snap_clears: assert property (@(posedge clk) disable iff (!rst_n)
        go && cmd == CMD_SNAP |=> frames_reg == '0 && psum_reg == '0 && imax_reg == '0)
        else $error("snapshot did not clear statistics");

    a_max_within_sum: assert property (@(posedge clk) disable iff (!rst_n)
        imax_reg <= isum_reg)
        else $error("interval maximum above interval sum");

    a_history_kept: assert property (@(posedge clk) disable iff (!rst_n)
        have_begin_reg |=> have_begin_reg)
        else $error("timing history lost");

    a_no_begin_no_frames: assert property (@(posedge clk) disable iff (!rst_n)
        !have_begin_reg |-> frames_reg == '0 && isum_reg == '0)
        else $error("frame measured without a previous begin");

endmodule

`default_nettype wire

>>> hdl/ftsm_result.sv
`default_nettype none

module ftsm_result
    import ftsm_pkg::*;
#(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire logic [COUNT_BITS-1:0] frames,
    input  wire logic [TIME_BITS-1:0]  isum,
    input  wire logic [TIME_BITS-1:0]  imax,
    input  wire logic [TIME_BITS-1:0]  psum,
    input  wire logic [COUNT_BITS-1:0] hist [BUCKETS],
    input  wire logic                  out_stall,
    output logic                       out_valid,
    output logic [COUNT_BITS-1:0]      frame_count,
    output logic [TIME_BITS-1:0]       frame_time_sum,
    output logic [TIME_BITS-1:0]       frame_time_max,
    output logic [TIME_BITS-1:0]       present_time_sum,
    output logic [COUNT_BITS-1:0]      bucket_zero,
    output logic [COUNT_BITS-1:0]      bucket_one,
    output logic [COUNT_BITS-1:0]      bucket_two,
    output logic [COUNT_BITS-1:0]      bucket_three,
    output logic [COUNT_BITS-1:0]      bucket_four
);

    logic valid_reg, valid_next;

    assign valid_next = load | (valid_reg & out_stall);
    assign out_valid  = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_count      <= frames;
            frame_time_sum   <= isum;
            frame_time_max   <= imax;
            present_time_sum <= psum;
            bucket_zero      <= hist[0];
            bucket_one       <= hist[1];
            bucket_two       <= hist[2];
            bucket_three     <= hist[3];
            bucket_four      <= hist[4];
        end
    end

endmodule

`default_nettype wire

>>> hdl/frame_time_stats_monitor.sv
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    command, time_us
// out      output     out_valid/out_stall  frame_count .. bucket_four
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item per cycle unless a snapshot stalls the input; an item sits in the input register,
// then updates the statistics registers
// a snapshot result passes through the input register and then the result register
// asynchronous active-low reset clears statistics and history and restores the default configuration
// a snapshot waits in the input register while the previous result is untaken,
// stalling the input; other commands never wait
`default_nettype none

module frame_time_stats_monitor
    import ftsm_pkg::*;
#(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 32
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [1:0]              command,
    input  wire logic [TIME_BITS-1:0]    time_us,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [COUNT_BITS-1:0]        frame_count,
    output logic [TIME_BITS-1:0]         frame_time_sum,
    output logic [TIME_BITS-1:0]         frame_time_max,
    output logic [TIME_BITS-1:0]         present_time_sum,
    output logic [COUNT_BITS-1:0]        bucket_zero,
    output logic [COUNT_BITS-1:0]        bucket_one,
    output logic [COUNT_BITS-1:0]        bucket_two,
    output logic [COUNT_BITS-1:0]        bucket_three,
    output logic [COUNT_BITS-1:0]        bucket_four,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [BOUND_BITS-1:0]   cfg_data
);

    cfg_t                  cfg;
    logic                  s1_valid_reg, s1_valid_next;
    logic [1:0]            s1_cmd_reg;
    logic [TIME_BITS-1:0]  s1_time_reg;
    logic                  s1_go;
    logic                  accept;
    logic                  load;
    logic [COUNT_BITS-1:0] frames;
    logic [TIME_BITS-1:0]  isum;
    logic [TIME_BITS-1:0]  imax;
    logic [TIME_BITS-1:0]  psum;
    logic [COUNT_BITS-1:0] hist [BUCKETS];

    assign s1_go = s1_valid_reg & ((s1_cmd_reg != CMD_SNAP) | ~out_valid | ~out_stall);
    assign in_stall      = s1_valid_reg & ~s1_go;
    assign accept        = in_valid & ~in_stall;
    assign s1_valid_next = accept | (s1_valid_reg & ~s1_go);
    assign load          = s1_go & (s1_cmd_reg == CMD_SNAP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= command;
            s1_time_reg <= time_us;
        end
    end

    ftsm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ftsm_stats #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_stats (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (s1_go),
        .cmd    (s1_cmd_reg),
        .now    (s1_time_reg),
        .cfg    (cfg),
        .frames (frames),
        .isum   (isum),
        .imax   (imax),
        .psum   (psum),
        .hist   (hist)
    );

    ftsm_result #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_result (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (load),
        .frames           (frames),
        .isum             (isum),
        .imax             (imax),
        .psum             (psum),
        .hist             (hist),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .frame_count      (frame_count),
        .frame_time_sum   (frame_time_sum),
        .frame_time_max   (frame_time_max),
        .present_time_sum (present_time_sum),
        .bucket_zero      (bucket_zero),
        .bucket_one       (bucket_one),
        .bucket_two       (bucket_two),
        .bucket_three     (bucket_three),
        .bucket_four      (bucket_four)
    );

endmodule

`default_nettype wire
